/* rtl/core/gef_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gef_pkg
// Shared types and constants of the gradient edge enhance filter.
// ----------------------------------------------------------------------------
package gef_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 3 * CHAN_W;
    localparam int IMG_W     = 13;
    localparam int CMP_W     = (IMG_W > COL_W + 1) ? IMG_W : COL_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int THR_BASE  = 100;
    localparam int CHAN_MAX  = 255;

    // request kinds
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // filter modes
    localparam logic MODE_ENHANCE = 1'b0;
    localparam logic MODE_LINE    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_MODE = 3'd0,
        CFG_EDGE_LEVEL  = 3'd1,
        CFG_SENSITIVITY = 3'd2,
        CFG_GRAY_MODE   = 3'd3,
        CFG_IMAGE_WIDTH = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              req_type;
        logic [CHAN_W-1:0] chan_red;
        logic [CHAN_W-1:0] chan_green;
        logic [CHAN_W-1:0] chan_blue;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              frame_done;
    } t_out_item;

    typedef struct packed {
        logic              filter_mode;
        logic [CHAN_W-1:0] edge_level;
        logic [CHAN_W-1:0] sensitivity;
    } t_filt_cfg;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [COL_W-1:0] wr_addr;
        logic [COL_W-1:0] rd_addr_cur;
        logic [COL_W-1:0] rd_addr_right;
        logic [PIX_W-1:0] wr_data;
    } t_lb_req;

endpackage

/* rtl/core/gef_line_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gef_line_buf
// One-row pixel store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module gef_line_buf (
    input  logic                      i_clk,
    input  gef_pkg::t_lb_req          i_req,
    output logic [gef_pkg::PIX_W-1:0] o_rd_cur,
    output logic [gef_pkg::PIX_W-1:0] o_rd_right
);

    logic [gef_pkg::PIX_W-1:0] r_mem [gef_pkg::MAX_WIDTH];
    logic [gef_pkg::PIX_W-1:0] r_rd_cur;
    logic [gef_pkg::PIX_W-1:0] r_rd_right;

    // reads return the old contents on a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_cur   <= r_mem[i_req.rd_addr_cur];
            r_rd_right <= r_mem[i_req.rd_addr_right];
        end
    end

    assign o_rd_cur   = r_rd_cur;
    assign o_rd_right = r_rd_right;

endmodule

/* rtl/core/gef_chan_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gef_chan_filter
// Gradient threshold and level shift for one 8-bit channel.
// ----------------------------------------------------------------------------
module gef_chan_filter (
    input  gef_pkg::t_filt_cfg         i_cfg,
    input  logic [gef_pkg::CHAN_W-1:0] i_cur,
    input  logic [gef_pkg::CHAN_W-1:0] i_right,
    input  logic [gef_pkg::CHAN_W-1:0] i_below,
    output logic [gef_pkg::CHAN_W-1:0] o_value
);

    logic signed [9:0] w_d_right;
    logic signed [9:0] w_d_below;
    logic signed [9:0] w_abs_right;
    logic signed [9:0] w_abs_below;
    logic        [8:0] w_grad;
    logic signed [9:0] w_thr;
    logic              w_edge;
    logic              w_neg;
    logic signed [9:0] w_shift;
    logic        [7:0] w_sat;

    assign w_d_right   = $signed({2'b00, i_cur}) - $signed({2'b00, i_right});
    assign w_d_below   = $signed({2'b00, i_cur}) - $signed({2'b00, i_below});
    assign w_abs_right = w_d_right[9] ? -w_d_right : w_d_right;
    assign w_abs_below = w_d_below[9] ? -w_d_below : w_d_below;
    assign w_grad      = {1'b0, w_abs_right[7:0]} + {1'b0, w_abs_below[7:0]};
    assign w_thr       = $signed(10'(gef_pkg::THR_BASE)) - $signed({2'b00, i_cfg.sensitivity});
    assign w_edge      = $signed({1'b0, w_grad}) > w_thr;
    assign w_neg       = w_d_right[9] | w_d_below[9];
    assign w_shift     = w_neg ? $signed({2'b00, i_cur}) - $signed({2'b00, i_cfg.edge_level})
                               : $signed({2'b00, i_cur}) + $signed({2'b00, i_cfg.edge_level});

    // clamp to 0..255
    always_comb begin
        if (w_shift[9]) begin
            w_sat = '0;
        end else if (w_shift[8]) begin
            w_sat = 8'(gef_pkg::CHAN_MAX);
        end else begin
            w_sat = w_shift[7:0];
        end
    end

    always_comb begin
        if (i_cfg.filter_mode == gef_pkg::MODE_LINE) begin
            o_value = w_edge ? '0 : 8'(gef_pkg::CHAN_MAX);
        end else begin
            o_value = w_edge ? w_sat : i_cur;
        end
    end

endmodule

/* rtl/core/gradient_edge_enhance_filter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_edge_enhance_filter_top
// Forward-difference gradient edge filter over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// The block passes each request through the line buffer read register and
// the result register when the output side is free; results come out one
// row behind the pixels that go in, and drain requests flush the final row
// with frame_done on its last pixel. The rate is one request per cycle
// while o_in_stall is low, set by the single filter stage that sits between
// the line buffer read register and the result register. The line buffer
// is a 4096 x 24 memory with one write port and two read ports (current
// column and its right neighbor); it needs no clearing pass after reset.
// First-row pixels and drains before a full row is held give no result.
// Write the configuration registers only while no request is in flight.
// ----------------------------------------------------------------------------
module gradient_edge_enhance_filter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  gef_pkg::t_in_item             i_in_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output gef_pkg::t_out_item            o_out_data,
    // configuration write port
    input  logic                          i_cfg_wen,
    input  logic [gef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gef_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    // configuration registers
    logic                         r_filter_mode;
    logic [gef_pkg::CHAN_W-1:0]   r_edge_level;
    logic [gef_pkg::CHAN_W-1:0]   r_sensitivity;
    logic                         r_gray_mode;
    logic [gef_pkg::IMG_W-1:0]    r_image_width;

    // frame position
    logic [gef_pkg::COL_W-1:0]    r_col;
    logic                         r_first_done;
    logic                         r_second_seen;

    // filter stage
    logic                         r_s1_valid;
    logic                         r_s1_emit;
    logic                         r_s1_drain;
    logic                         r_s1_second;
    logic                         r_s1_right_ok;
    logic                         r_s1_done;
    logic [gef_pkg::PIX_W-1:0]    r_s1_px;

    // result register
    logic                         r_out_valid;
    gef_pkg::t_out_item           r_out_data;

    logic [gef_pkg::CMP_W-1:0]    w_width;
    logic [gef_pkg::CMP_W-1:0]    w_col_inc;
    logic                         w_last;
    logic                         w_accept;
    logic                         w_is_pixel;
    logic                         w_out_ready;
    logic                         w_stall;
    logic [gef_pkg::PIX_W-1:0]    w_px;
    gef_pkg::t_lb_req             w_lb_req;
    logic [gef_pkg::PIX_W-1:0]    w_rd_cur;
    logic [gef_pkg::PIX_W-1:0]    w_rd_right;
    logic [gef_pkg::PIX_W-1:0]    w_right;
    logic [gef_pkg::PIX_W-1:0]    w_below;
    logic [gef_pkg::PIX_W-1:0]    w_filt;
    gef_pkg::t_filt_cfg           w_filt_cfg;
    gef_pkg::t_out_item           n_out_data;

    // width in use: 0 acts as 1, anything above the buffer depth clamps to it
    always_comb begin
        if (r_image_width == '0) begin
            w_width = gef_pkg::CMP_W'(1);
        end else if (gef_pkg::CMP_W'(r_image_width) > gef_pkg::CMP_W'(gef_pkg::MAX_WIDTH)) begin
            w_width = gef_pkg::CMP_W'(gef_pkg::MAX_WIDTH);
        end else begin
            w_width = gef_pkg::CMP_W'(r_image_width);
        end
    end

    assign w_col_inc  = gef_pkg::CMP_W'(r_col) + gef_pkg::CMP_W'(1);
    assign w_last     = w_col_inc >= w_width;
    assign w_is_pixel = (i_in_data.req_type == gef_pkg::REQ_PIXEL);
    assign w_px       = {i_in_data.chan_blue, i_in_data.chan_green, i_in_data.chan_red};

    // handshake: the filter stage only blocks when it holds a result that
    // cannot move into a full, stalled result register
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_stall     = r_s1_valid && r_s1_emit && !w_out_ready;
    assign w_accept    = i_in_valid && !w_stall;
    assign o_in_stall  = w_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= 1'b0;
            r_edge_level  <= '0;
            r_sensitivity <= '0;
            r_gray_mode   <= 1'b0;
            r_image_width <= gef_pkg::IMG_W'(1);
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                gef_pkg::CFG_FILTER_MODE: r_filter_mode <= i_cfg_data[0];
                gef_pkg::CFG_EDGE_LEVEL:  r_edge_level  <= i_cfg_data[gef_pkg::CHAN_W-1:0];
                gef_pkg::CFG_SENSITIVITY: r_sensitivity <= i_cfg_data[gef_pkg::CHAN_W-1:0];
                gef_pkg::CFG_GRAY_MODE:   r_gray_mode   <= i_cfg_data[0];
                gef_pkg::CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data[gef_pkg::IMG_W-1:0];
                default: ;
            endcase
        end
    end

    // frame position: advance on pixels, and on drains once a row is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_first_done  <= 1'b0;
            r_second_seen <= 1'b0;
        end else if (w_accept) begin
            if (w_is_pixel) begin
                if (r_first_done) begin
                    r_second_seen <= 1'b1;
                end
                if (w_last) begin
                    r_col        <= '0;
                    r_first_done <= 1'b1;
                end else begin
                    r_col <= w_col_inc[gef_pkg::COL_W-1:0];
                end
            end else if (r_first_done) begin
                if (w_last) begin
                    r_col         <= '0;
                    r_first_done  <= 1'b0;
                    r_second_seen <= 1'b0;
                end else begin
                    r_col <= w_col_inc[gef_pkg::COL_W-1:0];
                end
            end
        end
    end

    // line buffer: read the buffered row at the current column and its right
    // neighbor, and store the new pixel in the same column on the same edge
    always_comb begin
        w_lb_req.wr_en         = w_accept && w_is_pixel;
        w_lb_req.rd_en         = w_accept;
        w_lb_req.wr_addr       = r_col;
        w_lb_req.rd_addr_cur   = r_col;
        w_lb_req.rd_addr_right = w_col_inc[gef_pkg::COL_W-1:0];
        w_lb_req.wr_data       = w_px;
    end

    gef_line_buf u_line_buf (
        .i_clk      (i_clk),
        .i_req      (w_lb_req),
        .o_rd_cur   (w_rd_cur),
        .o_rd_right (w_rd_right)
    );

    // filter stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!w_stall) begin
            r_s1_valid <= w_accept;
        end
    end

    // filter stage payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_emit     <= r_first_done;
            r_s1_drain    <= !w_is_pixel;
            r_s1_second   <= r_second_seen;
            r_s1_right_ok <= !w_last;
            r_s1_done     <= !w_is_pixel && w_last;
            r_s1_px       <= w_px;
        end
    end

    // right neighbor past the last column is 0; drain uses the pixel itself
    // as its below neighbor, or 0 for a one-row image
    assign w_right = r_s1_right_ok ? w_rd_right : '0;
    always_comb begin
        if (!r_s1_drain) begin
            w_below = r_s1_px;
        end else if (r_s1_second) begin
            w_below = w_rd_cur;
        end else begin
            w_below = '0;
        end
    end

    assign w_filt_cfg.filter_mode = r_filter_mode;
    assign w_filt_cfg.edge_level  = r_edge_level;
    assign w_filt_cfg.sensitivity = r_sensitivity;

    for (genvar g = 0; g < 3; g++) begin : g_chan
        gef_chan_filter u_chan_filter (
            .i_cfg   (w_filt_cfg),
            .i_cur   (w_rd_cur[g*gef_pkg::CHAN_W +: gef_pkg::CHAN_W]),
            .i_right (w_right[g*gef_pkg::CHAN_W +: gef_pkg::CHAN_W]),
            .i_below (w_below[g*gef_pkg::CHAN_W +: gef_pkg::CHAN_W]),
            .o_value (w_filt[g*gef_pkg::CHAN_W +: gef_pkg::CHAN_W])
        );
    end

    // gray mode: drop the second and third channels
    always_comb begin
        n_out_data.out_red    = w_filt[gef_pkg::CHAN_W-1:0];
        n_out_data.out_green  = r_gray_mode ? '0 : w_filt[2*gef_pkg::CHAN_W-1:gef_pkg::CHAN_W];
        n_out_data.out_blue   = r_gray_mode ? '0 : w_filt[3*gef_pkg::CHAN_W-1:2*gef_pkg::CHAN_W];
        n_out_data.frame_done = r_s1_done;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/core/gef_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gef_checker
// Port-level checks on the gradient edge filter, bound to the top level.
// ----------------------------------------------------------------------------
module gef_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  gef_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_wen,
    input  logic [gef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gef_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    logic r_gray_mode;

    // track the gray mode register from the configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_mode <= 1'b0;
        end else if (i_cfg_wen && (i_cfg_index == gef_pkg::CFG_GRAY_MODE)) begin
            r_gray_mode <= i_cfg_data[0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("request stalled with empty result register");

    a_gray_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_gray_mode |-> o_out_data.out_green == '0 && o_out_data.out_blue == '0)
        else $error("gray result carries color channels");

endmodule

bind gradient_edge_enhance_filter_top gef_checker u_gef_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .i_cfg_wen   (i_cfg_wen),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gradient edge enhance filter.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and offered by a clocked
// driver. A clocked monitor runs a bit-accurate predictor of the filter on
// every accepted request and checks each accepted result, field by field,
// against the oldest predicted pixel. Stimulus covers a short directed set,
// then random phases of well-formed frames mixed with stray requests under
// varying settings and backpressure, then an oversize width that is shrunk
// in the middle of a row.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    // ---- clock and DUT ports (driven ones known from time zero) -------------
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    gef_pkg::t_in_item             i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    gef_pkg::t_out_item            o_out_data;
    logic                          i_cfg_wen   = 1'b0;
    logic [gef_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [gef_pkg::CFG_DAT_W-1:0] i_cfg_data  = '0;

    always #5 i_clk = ~i_clk;

    gradient_edge_enhance_filter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ---- bench state -------------------------------------------------------
    gef_pkg::t_in_item  pix_feed[$];      // requests waiting to be offered
    gef_pkg::t_out_item due_pixels[$];    // predicted results, oldest first
    int        mismatches   = 0;
    int        tx_idle_pct  = 0;
    int        rx_idle_pct  = 0;
    int        rx_hold_asks = 0;
    int        chan_band    = 0; // low end of the narrow pixel band
    int        cycles       = 0;

    // ---- predictor state: configuration copy and filter state --------------
    logic                       cfg_mode   = gef_pkg::MODE_ENHANCE;
    logic [gef_pkg::CHAN_W-1:0] cfg_level  = '0;
    logic [gef_pkg::CHAN_W-1:0] cfg_sens   = '0;
    logic                       cfg_gray   = 1'b0;
    logic [gef_pkg::IMG_W-1:0]  cfg_width  = gef_pkg::IMG_W'(1);
    logic [gef_pkg::PIX_W-1:0]  line_buf [gef_pkg::MAX_WIDTH];
    int                         col_pos    = 0;
    logic                       row_held   = 1'b0;
    logic                       second_row = 1'b0;

    // Width actually in use: zero acts as one, oversize clamps to the buffer.
    function automatic int span();
        if (cfg_width == 0) return 1;
        if (cfg_width > gef_pkg::MAX_WIDTH) return gef_pkg::MAX_WIDTH;
        return int'(cfg_width);
    endfunction

    // Filter one channel given its right and below neighbors.
    function automatic logic [gef_pkg::CHAN_W-1:0] shade(int cur, int right, int below);
        int   d1, d2, grad, v;
        logic neg, hit;
        d1   = cur - right;
        d2   = cur - below;
        neg  = (d1 < 0) || (d2 < 0);
        grad = (d1 < 0 ? -d1 : d1) + (d2 < 0 ? -d2 : d2);
        // threshold is signed: high sensitivity pushes it below zero
        hit  = grad > (gef_pkg::THR_BASE - int'(cfg_sens));
        if (cfg_mode == gef_pkg::MODE_LINE) begin
            return hit ? gef_pkg::CHAN_W'(0) : gef_pkg::CHAN_W'(gef_pkg::CHAN_MAX);
        end
        if (!hit) return gef_pkg::CHAN_W'(cur);
        v = neg ? cur - int'(cfg_level) : cur + int'(cfg_level);
        if (v < 0) v = 0;
        else if (v > gef_pkg::CHAN_MAX) v = gef_pkg::CHAN_MAX;
        return gef_pkg::CHAN_W'(v);
    endfunction

    // Predict the output pixel for buffered column col.
    task automatic queue_result(int col, int w, logic [gef_pkg::PIX_W-1:0] below,
                                logic done);
        logic [gef_pkg::PIX_W-1:0] cur, right;
        gef_pkg::t_out_item        r;
        cur   = line_buf[col];
        // right neighbor of the last column reads as zero
        right = (col + 1 < w) ? line_buf[col + 1] : '0;
        r.out_red    = shade(cur[7:0], right[7:0], below[7:0]);
        r.out_green  = cfg_gray ? '0 : shade(cur[15:8], right[15:8], below[15:8]);
        r.out_blue   = cfg_gray ? '0 : shade(cur[23:16], right[23:16], below[23:16]);
        r.frame_done = done;
        due_pixels.push_back(r);
    endtask

    // Advance the filter state by one accepted request.
    task automatic filter_pixel(gef_pkg::t_in_item req);
        int                        w, c;
        logic                      last;
        logic [gef_pkg::PIX_W-1:0] px;
        w    = span();
        c    = col_pos;
        // a column at or past the width counts as the last one
        last = (c + 1 >= w);
        px   = {req.chan_blue, req.chan_green, req.chan_red};
        if (req.req_type == gef_pkg::REQ_PIXEL) begin
            if (row_held) begin
                queue_result(c, w, px, 1'b0);
                second_row = 1'b1;
            end
            line_buf[c] = px;
            if (last) begin
                col_pos  = 0;
                row_held = 1'b1;
            end else begin
                col_pos = c + 1;
            end
        end else if (row_held) begin
            // drain: below is the pixel itself, or zero for a one-row image
            queue_result(c, w, second_row ? line_buf[c] : '0, last);
            if (last) begin
                col_pos    = 0;
                row_held   = 1'b0;
                second_row = 1'b0;
            end else begin
                col_pos = c + 1;
            end
        end
        // drain with no full row held: dropped, nothing changes
    endtask

    // ---- driver: offer queued requests, hold them while stalled ------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pix_feed.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pix_feed.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    task automatic cmp_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ---- monitor: predict on accepted requests, check accepted results -----
    int rx_hold_seen = 0;
    int rx_hold_left = 0;

    always @(posedge i_clk) begin : result_check
        gef_pkg::t_out_item want;
        if (i_rst_n) begin
            // predict first so a request and its result may share an edge
            if (i_in_valid && !o_in_stall) filter_pixel(i_in_data);
            if (o_out_valid && !i_out_stall) begin
                if (due_pixels.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, o_out_data);
                    mismatches++;
                end else begin
                    want = due_pixels.pop_front();
                    cmp_field("out_red",    want.out_red,    o_out_data.out_red);
                    cmp_field("out_green",  want.out_green,  o_out_data.out_green);
                    cmp_field("out_blue",   want.out_blue,   o_out_data.out_blue);
                    cmp_field("frame_done", want.frame_done, o_out_data.frame_done);
                end
            end
            // long hold-off on request, else random stalls
            if (rx_hold_asks != rx_hold_seen) begin
                rx_hold_seen = rx_hold_asks;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // ---- run limit ---------------------------------------------------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // ---- stimulus helpers --------------------------------------------------
    function automatic logic [gef_pkg::CHAN_W-1:0] pick_chan();
        case ($urandom_range(0, 7))
            0:       return gef_pkg::CHAN_W'(0);
            1:       return gef_pkg::CHAN_W'(gef_pkg::CHAN_MAX);
            2, 3:    return gef_pkg::CHAN_W'($urandom_range(0, gef_pkg::CHAN_MAX));
            // narrow band gives small gradients, so non-edges show up too
            default: return gef_pkg::CHAN_W'(chan_band + $urandom_range(0, 40));
        endcase
    endfunction

    task automatic push_req(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        gef_pkg::t_in_item it;
        it.req_type   = kind;
        it.chan_red   = r;
        it.chan_green = g;
        it.chan_blue  = b;
        pix_feed.push_back(it);
    endtask

    task automatic push_rand(logic kind);
        push_req(kind, pick_chan(), pick_chan(), pick_chan());
    endtask

    // Write one register while idle and mirror it into the predictor.
    task automatic write_reg(gef_pkg::t_cfg_idx idx, int val);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= gef_pkg::CFG_DAT_W'(val);
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            gef_pkg::CFG_FILTER_MODE: cfg_mode  = val[0];
            gef_pkg::CFG_EDGE_LEVEL:  cfg_level = val[7:0];
            gef_pkg::CFG_SENSITIVITY: cfg_sens  = val[7:0];
            gef_pkg::CFG_GRAY_MODE:   cfg_gray  = val[0];
            gef_pkg::CFG_IMAGE_WIDTH: cfg_width = val[gef_pkg::IMG_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every request is taken and every result has come, then
    // give requests that make no result time to leave the pipeline.
    task automatic settle();
        do @(posedge i_clk);
        while (pix_feed.size() != 0 || i_in_valid || due_pixels.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Bring the filter back to a frame boundary so the width may grow safely.
    task automatic close_frame();
        int w, c, n_px, n_dr;
        settle();
        w    = span();
        c    = col_pos;
        n_px = 0;
        if (!row_held && c == 0) return;
        if (!row_held) begin
            n_px = (c >= w) ? 1 : w - c;
            c    = 0;
        end
        n_dr = (c >= w) ? 1 : w - c;
        repeat (n_px) push_rand(gef_pkg::REQ_PIXEL);
        repeat (n_dr) push_rand(gef_pkg::REQ_DRAIN);
        settle();
    endtask

    // ---- stimulus ----------------------------------------------------------
    initial begin
        int   ph, sent, rows, w;
        logic paused;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, one-row image, drain ignored, width shrink
        tx_idle_pct = 7;
        rx_idle_pct = 77;
        write_reg(gef_pkg::CFG_FILTER_MODE, gef_pkg::MODE_ENHANCE);
        write_reg(gef_pkg::CFG_EDGE_LEVEL, 255);
        write_reg(gef_pkg::CFG_SENSITIVITY, 0);
        write_reg(gef_pkg::CFG_GRAY_MODE, 0);
        write_reg(gef_pkg::CFG_IMAGE_WIDTH, 3);
        push_req(gef_pkg::REQ_DRAIN, 8'd255, 8'd255, 8'd255);   // no row held yet: drop
        push_req(gef_pkg::REQ_PIXEL, 8'd0,   8'd255, 8'd0);
        push_req(gef_pkg::REQ_PIXEL, 8'd255, 8'd0,   8'd128);
        push_req(gef_pkg::REQ_PIXEL, 8'd0,   8'd0,   8'd255);
        push_req(gef_pkg::REQ_PIXEL, 8'd255, 8'd255, 8'd255);
        push_req(gef_pkg::REQ_PIXEL, 8'd0,   8'd0,   8'd0);
        push_req(gef_pkg::REQ_PIXEL, 8'd128, 8'd128, 8'd128);
        repeat (3) push_req(gef_pkg::REQ_DRAIN, 8'd0, 8'd0, 8'd0);
        settle();

        // zero width acts as one column; single row drains against zero
        write_reg(gef_pkg::CFG_IMAGE_WIDTH, 0);
        write_reg(gef_pkg::CFG_GRAY_MODE, 1);
        write_reg(gef_pkg::CFG_FILTER_MODE, gef_pkg::MODE_LINE);
        push_req(gef_pkg::REQ_PIXEL, 8'd200, 8'd17, 8'd99);
        push_req(gef_pkg::REQ_DRAIN, 8'd0, 8'd0, 8'd0);
        settle();

        // shrink the width mid-row: the column past the end is the last one
        write_reg(gef_pkg::CFG_FILTER_MODE, gef_pkg::MODE_ENHANCE);
        write_reg(gef_pkg::CFG_GRAY_MODE, 0);
        write_reg(gef_pkg::CFG_EDGE_LEVEL, 60);
        write_reg(gef_pkg::CFG_SENSITIVITY, 40);
        write_reg(gef_pkg::CFG_IMAGE_WIDTH, 5);
        repeat (8) push_rand(gef_pkg::REQ_PIXEL);
        settle();
        write_reg(gef_pkg::CFG_IMAGE_WIDTH, 2);
        repeat (3) push_rand(gef_pkg::REQ_PIXEL);
        repeat (2) push_rand(gef_pkg::REQ_DRAIN);
        settle();

        // random phases: mostly whole frames, some stray requests
        paused = 1'b0;
        for (ph = 0; ph < 8; ph++) begin
            close_frame();
            if (ph < 3) begin
                tx_idle_pct = 7;
                rx_idle_pct = 77;
            end else if (ph < 6) begin
                tx_idle_pct = 77;
                rx_idle_pct = 7;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_reg(gef_pkg::CFG_FILTER_MODE, ph % 2);
            write_reg(gef_pkg::CFG_EDGE_LEVEL, (ph == 1) ? 0 : (ph == 2) ? 255
                                               : $urandom_range(0, 255));
            write_reg(gef_pkg::CFG_SENSITIVITY, (ph == 3) ? 255 : (ph == 4) ? 0
                                                : $urandom_range(0, 255));
            write_reg(gef_pkg::CFG_GRAY_MODE, (ph / 2) % 2);
            write_reg(gef_pkg::CFG_IMAGE_WIDTH, (ph == 0) ? 1 : (ph == 3) ? 0
                                                : $urandom_range(2, 16));
            chan_band = $urandom_range(0, 215);
            w = span();
            // hold the result side off while requests keep coming
            if (ph == 6) rx_hold_asks++;
            sent = 0;
            while (sent < 190) begin
                if ($urandom_range(0, 9) == 0) begin
                    rows = $urandom_range(1, 4);
                    repeat (rows) push_rand(logic'($urandom_range(0, 1)));
                    sent += rows;
                end else begin
                    rows = $urandom_range(1, 3);
                    repeat (rows * w) push_rand(gef_pkg::REQ_PIXEL);
                    repeat (w) push_rand(gef_pkg::REQ_DRAIN);
                    sent += (rows + 1) * w;
                end
                // pause the sender once until every result is back
                if (ph == 7 && sent >= 100 && !paused) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        // oversize width setting, then shrink it in the middle of the row
        close_frame();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(gef_pkg::CFG_FILTER_MODE, gef_pkg::MODE_ENHANCE);
        write_reg(gef_pkg::CFG_EDGE_LEVEL, $urandom_range(0, 255));
        write_reg(gef_pkg::CFG_SENSITIVITY, $urandom_range(0, 255));
        write_reg(gef_pkg::CFG_IMAGE_WIDTH, 8191);
        chan_band = $urandom_range(0, 215);
        repeat (3) push_rand(gef_pkg::REQ_PIXEL);
        settle();
        write_reg(gef_pkg::CFG_IMAGE_WIDTH, 2);
        repeat (3) push_rand(gef_pkg::REQ_PIXEL);
        repeat (2) push_rand(gef_pkg::REQ_DRAIN);
        settle();

        if (mismatches == 0 && due_pixels.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
